### src/weno5_pkg.sv
// shared constants for the weno5 face reconstruction pipeline
// no dependencies; imported by weno5_face_reconstruction
`default_nettype none

package weno5_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  // normalized smoothness width, weight fraction bits, reciprocal numerator exponent
  localparam int NORM_BITS  = 20;
  localparam int WGT_BITS   = 24;
  localparam int RECIP_BITS = 60;
  localparam int ALPHA_BITS = 32;
  localparam int EPS_WIDTH  = 32;

  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd4295;

  // flow direction codes
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // quotient bits resolved per pipeline stage
  localparam int DIV1_STEPS = 2;
  localparam int DIV2_STEPS = 2;

endpackage

`default_nettype wire

### src/weno5_face_reconstruction.sv
// fifth-order weno face reconstruction, fully pipelined, one face per beat
// depends on weno5_pkg (constants, direction codes, divider step counts)
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: six samples, flow_direction
//  out_    | out | out_tvalid/out_tready| out_tdata: face_value, saturated
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: smooth_epsilon
//
// one beat per cycle sustained while the skid register is empty; most of the
// pipeline depth lies in the two restoring quotient pipelines (reciprocal of the
// squared indicator, weight normalization)
// reset clears all valid bits and the skid register, epsilon returns to 4295
// a one-beat skid register follows the output stage; while it holds a beat the
// whole pipeline freezes, so nothing is dropped or repeated
`default_nettype none

module weno5_face_reconstruction
  import weno5_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_TW  = ((6 * DATA_WIDTH + 2 + 7) / 8) * 8,
  localparam int OUT_TW = ((DATA_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // lowest first: sample_m2, sample_m1, sample_0, sample_p1, sample_p2, sample_p3,
  // flow_direction, zero pad
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_TW-1:0]     in_tdata,
  // lowest first: face_value, saturated, zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_TW-1:0]    out_tdata,
  // smooth_epsilon
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [EPS_WIDTH-1:0] cfg_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int PW  = DW + 5;              // signed stencil sums
  localparam int MW  = DW + 3;              // magnitude of difference terms
  localparam int HL  = (MW + 1) / 2;        // low half for squaring
  localparam int HH  = MW - HL;
  localparam int SQW = 2 * MW;
  localparam int JW  = (2 * MW + 5 > 2 * FRAC_BITS + 5) ? 2 * MW + 5 : 2 * FRAC_BITS + 5;
  localparam int EXW = JW + 32;
  localparam int LW  = $clog2(JW + 1);
  localparam int DVW = 2 * NORM_BITS;
  localparam int R1W = DVW + 1;
  localparam int Q1W = RECIP_BITS + 1;
  localparam int ALW = Q1W + 3;
  localparam int SHW = $clog2(ALW + 1);
  localparam int R2W = ALPHA_BITS + 1;
  localparam int Q2W = WGT_BITS + 1;
  localparam int PLW = (PW + 1) / 2;
  localparam int PHW = PW - PLW;
  localparam int NW  = WGT_BITS + PW + 3;
  localparam int Y2W = NW - WGT_BITS - 1;
  localparam int UW  = DW + 2;
  localparam int D1N = (Q1W + DIV1_STEPS - 1) / DIV1_STEPS;
  localparam int D2N = (Q2W + DIV2_STEPS - 1) / DIV2_STEPS;
  localparam int D3N = 2;                   // split products, then sum and shift

  // divide by three as a multiply by ceil(2^RCK / 3)
  localparam int RCK = UW + 2;
  localparam int ML  = (UW + 1) / 2;
  localparam int RMW = UW + 1;
  localparam int RHW = RMW - ML;
  localparam int UHW = UW - ML;
  localparam int PRW = 2 * UW + 2;
  localparam logic [RCK:0]   RC_P2   = {1'b1, {RCK{1'b0}}};
  localparam logic [RCK:0]   RC_FULL = (RC_P2 + (RCK + 1)'(2)) / (RCK + 1)'(3);
  localparam logic [RMW-1:0] RC_M    = RC_FULL[RMW-1:0];

  // stage map
  localparam int ST_IN  = 0;
  localparam int ST_PP  = 1;
  localparam int ST_J   = 2;
  localparam int ST_LEN = 3;
  localparam int ST_ISN = 4;
  localparam int ST_SQ  = 5;
  localparam int ST_D1  = 6;
  localparam int ST_AL  = ST_D1 + D1N;
  localparam int ST_SL  = ST_AL + 1;
  localparam int ST_AS  = ST_SL + 1;
  localparam int ST_D2  = ST_AS + 1;
  localparam int ST_MP  = ST_D2 + D2N;
  localparam int ST_NM  = ST_MP + 1;
  localparam int ST_CL  = ST_NM + 1;
  localparam int ST_D3  = ST_CL + 1;
  localparam int ST_OUT = ST_D3 + D3N;
  localparam int NST    = ST_OUT + 1;

  // clamp window on the value before the final divide by three
  localparam logic signed [Y2W-1:0] CL_HI = (Y2W'(3) << (DW - 1)) - Y2W'(1);
  localparam logic signed [Y2W-1:0] CL_LO = ~CL_HI;

  // side data that rides along every stage
  typedef struct packed {
    logic                sat;
    logic                zero;
    logic [2:0][PW-1:0]  p;
  } carry_t;

  function automatic logic [MW-1:0] mag_f(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] n;
    n = x[PW-1] ? -x : x;
    return n[MW-1:0];
  endfunction

  function automatic logic [SQW-1:0] sq_join(input logic [2*HL-1:0] ll,
                                             input logic [MW-1:0] hl,
                                             input logic [2*HH-1:0] hh);
    return (SQW'(hh) << (2 * HL)) + (SQW'(hl) << (HL + 1)) + SQW'(ll);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration and flow control
  // ---------------------------------------------------------------------------
  logic [EPS_WIDTH-1:0] eps_r;
  logic [NST-1:0]       vld_r;
  logic                 en;
  logic                 sk_v_r;
  logic [DW-1:0]        sk_val_r, o_val_r;
  logic                 sk_sat_r, o_sat_r;

  assign cfg_ready = 1'b1;
  assign en        = !sk_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // skid register: catches the output beat when the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (out_tready) sk_v_r <= 1'b0;
    end else if (vld_r[ST_OUT] && !out_tready) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v_r) begin
      sk_val_r <= o_val_r;
      sk_sat_r <= o_sat_r;
    end
  end

  assign out_tvalid = sk_v_r || vld_r[ST_OUT];
  assign out_tdata  = sk_v_r ? OUT_TW'({sk_sat_r, sk_val_r}) : OUT_TW'({o_sat_r, o_val_r});

  // ---------------------------------------------------------------------------
  // stage 0: stencil orientation, difference terms, candidate polynomials
  // ---------------------------------------------------------------------------
  carry_t            cr_r [NST];
  carry_t            cr0_nxt;
  logic [MW-1:0]     m_nxt [6];
  logic [MW-1:0]     m_r [6];

  always_comb begin
    logic signed [PW-1:0] s [6];
    logic signed [PW-1:0] q [5];
    logic [1:0]           dir;
    logic signed [PW-1:0] a0, a1, a2, b0, b1, b2, p0, p1, p2;
    for (int k = 0; k < 6; k++) begin
      s[k] = PW'($signed(in_tdata[k*DW +: DW]));
    end
    dir = in_tdata[6*DW +: 2];
    if (dir == DIR_NEG) begin
      // mirrored stencil over -1..+3
      q[0] = s[5]; q[1] = s[4]; q[2] = s[3]; q[3] = s[2]; q[4] = s[1];
    end else begin
      q[0] = s[0]; q[1] = s[1]; q[2] = s[2]; q[3] = s[3]; q[4] = s[4];
    end
    a0 = q[0] - (q[1] <<< 1) + q[2];
    b0 = q[0] - (q[1] <<< 2) + (q[2] <<< 1) + q[2];
    a1 = q[1] - (q[2] <<< 1) + q[3];
    b1 = q[1] - q[3];
    a2 = q[2] - (q[3] <<< 1) + q[4];
    b2 = (q[2] <<< 1) + q[2] - (q[3] <<< 2) + q[4];
    p0 = (q[0] <<< 1) - ((q[1] <<< 3) - q[1]) + (q[2] <<< 3) + (q[2] <<< 1) + q[2];
    p1 = (q[2] <<< 2) + q[2] - q[1] + (q[3] <<< 1);
    p2 = (q[2] <<< 1) + (q[3] <<< 2) + q[3] - q[4];
    m_nxt[0] = mag_f(a0);
    m_nxt[1] = mag_f(a1);
    m_nxt[2] = mag_f(a2);
    m_nxt[3] = mag_f(b0);
    m_nxt[4] = mag_f(b1);
    m_nxt[5] = mag_f(b2);
    cr0_nxt.sat  = 1'b0;
    // unused direction code counts as zero velocity
    cr0_nxt.zero = !(dir == DIR_POS || dir == DIR_NEG);
    cr0_nxt.p[0] = p0;
    cr0_nxt.p[1] = p1;
    cr0_nxt.p[2] = p2;
  end

  // ---------------------------------------------------------------------------
  // stages 1-5: squares, smoothness sums, normalization, squared indicator
  // ---------------------------------------------------------------------------
  logic [2*HL-1:0]    pp_ll_r [6];
  logic [MW-1:0]      pp_hl_r [6];
  logic [2*HH-1:0]    pp_hh_r [6];
  logic [JW-1:0]      j_r [3];
  logic [JW-1:0]      jl_r [3];
  logic [LW-1:0]      len_r;
  logic [NORM_BITS-1:0] isn_r [3];
  logic [DVW-1:0]     sq_d_r [3];

  logic [JW-1:0]      e_j;
  logic [JW-1:0]      j_nxt [3];
  logic [LW-1:0]      len_nxt;
  logic [NORM_BITS-1:0] isn_nxt [3];

  // epsilon rescaled from 2^-32 to the squared fraction, times twelve
  always_comb begin
    logic [EPS_WIDTH+3:0] eps12;
    logic [EXW-1:0]       e_ext;
    eps12 = ({4'b0, eps_r} << 3) + ({4'b0, eps_r} << 2);
    e_ext = EXW'(eps12) << (2 * FRAC_BITS);
    e_j   = e_ext[EXW-1:32];
  end

  always_comb begin
    logic [JW-1:0] sa, sb;
    for (int k = 0; k < 3; k++) begin
      sa = JW'(sq_join(pp_ll_r[k], pp_hl_r[k], pp_hh_r[k]));
      sb = JW'(sq_join(pp_ll_r[k+3], pp_hl_r[k+3], pp_hh_r[k+3]));
      j_nxt[k] = (sa << 3) + (sa << 2) + sa + (sb << 1) + sb + e_j;
    end
  end

  // bit length of the largest indicator equals that of the or of all three
  always_comb begin
    logic [JW-1:0] jor;
    jor = j_r[0] | j_r[1] | j_r[2];
    len_nxt = '0;
    for (int i = 0; i < JW; i++) begin
      if (jor[i]) len_nxt = LW'(i + 1);
    end
  end

  always_comb begin
    logic [JW-1:0] t;
    for (int k = 0; k < 3; k++) begin
      if (len_r > LW'(NORM_BITS)) t = jl_r[k] >> (len_r - LW'(NORM_BITS));
      else                        t = jl_r[k] << (LW'(NORM_BITS) - len_r);
      isn_nxt[k] = (t[NORM_BITS-1:0] == '0) ? NORM_BITS'(1) : t[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        m_r[i]     <= m_nxt[i];
        pp_ll_r[i] <= m_r[i][HL-1:0] * m_r[i][HL-1:0];
        pp_hl_r[i] <= MW'(m_r[i][MW-1:HL] * m_r[i][HL-1:0]);
        pp_hh_r[i] <= m_r[i][MW-1:HL] * m_r[i][MW-1:HL];
      end
      for (int k = 0; k < 3; k++) begin
        j_r[k]    <= j_nxt[k];
        jl_r[k]   <= j_r[k];
        isn_r[k]  <= isn_nxt[k];
        sq_d_r[k] <= isn_r[k] * isn_r[k];
      end
      len_r <= len_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // reciprocal pipeline: floor(2^60 / isn^2), restoring, per lane
  // ---------------------------------------------------------------------------
  logic [R1W-1:0] d1_rem_r [D1N][3];
  logic [Q1W-1:0] d1_q_r   [D1N][3];
  logic [DVW-1:0] d1_d_r   [D1N][3];

  for (genvar t = 0; t < D1N; t++) begin : g_d1
    logic [R1W-1:0] rem_i [3];
    logic [Q1W-1:0] q_i   [3];
    logic [DVW-1:0] d_i   [3];
    logic [R1W-1:0] rem_nxt [3];
    logic [Q1W-1:0] q_nxt   [3];
    if (t == 0) begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = '0;
          q_i[l]   = '0;
          d_i[l]   = sq_d_r[l];
        end
      end
    end else begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = d1_rem_r[t-1][l];
          q_i[l]   = d1_q_r[t-1][l];
          d_i[l]   = d1_d_r[t-1][l];
        end
      end
    end
    always_comb begin
      logic [R1W-1:0] r;
      logic [Q1W-1:0] q;
      logic           ge;
      for (int l = 0; l < 3; l++) begin
        r  = rem_i[l];
        q  = q_i[l];
        ge = 1'b0;
        for (int j = 0; j < DIV1_STEPS; j++) begin
          if (t * DIV1_STEPS + j < Q1W) begin
            // numerator is a single one at its top bit
            r  = {r[R1W-2:0], (t * DIV1_STEPS + j == 0)};
            ge = (r >= {1'b0, d_i[l]});
            if (ge) r = r - {1'b0, d_i[l]};
            q  = {q[Q1W-2:0], ge};
          end
        end
        rem_nxt[l] = r;
        q_nxt[l]   = q;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          d1_rem_r[t][l] <= rem_nxt[l];
          d1_q_r[t][l]   <= q_nxt[l];
          d1_d_r[t][l]   <= d_i[l];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // alpha weighting, common right shift to 32 bits
  // ---------------------------------------------------------------------------
  logic [ALW-1:0]        al_r [3];
  logic [ALW-1:0]        al_sl_r [3];
  logic [ALW-1:0]        asum_r;
  logic [SHW-1:0]        sh_r;
  logic [ALPHA_BITS-1:0] als_r [3];
  logic [ALPHA_BITS-1:0] a2_r;

  logic [ALW-1:0]        al_nxt [3];
  logic [SHW-1:0]        sh_nxt;
  logic [ALPHA_BITS-1:0] als_nxt [3];
  logic [ALPHA_BITS-1:0] a2_nxt;

  always_comb begin
    logic [ALW-1:0] q;
    q = ALW'(d1_q_r[D1N-1][0]);
    al_nxt[0] = q;
    q = ALW'(d1_q_r[D1N-1][1]);
    al_nxt[1] = (q << 2) + (q << 1);
    q = ALW'(d1_q_r[D1N-1][2]);
    al_nxt[2] = (q << 1) + q;
  end

  always_comb begin
    logic [SHW-1:0] la;
    la = '0;
    for (int i = 0; i < ALW; i++) begin
      if (asum_r[i]) la = SHW'(i + 1);
    end
    sh_nxt = (la > SHW'(ALPHA_BITS)) ? la - SHW'(ALPHA_BITS) : '0;
  end

  always_comb begin
    logic [ALW-1:0]        t;
    logic [ALPHA_BITS+1:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      t          = al_sl_r[k] >> sh_r;
      als_nxt[k] = t[ALPHA_BITS-1:0];
      s          = s + (ALPHA_BITS + 2)'(als_nxt[k]);
    end
    a2_nxt = (s[ALPHA_BITS-1:0] == '0) ? ALPHA_BITS'(1) : s[ALPHA_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        al_r[k]    <= al_nxt[k];
        al_sl_r[k] <= al_r[k];
        als_r[k]   <= als_nxt[k];
      end
      asum_r <= al_nxt[0] + al_nxt[1] + al_nxt[2];
      sh_r   <= sh_nxt;
      a2_r   <= a2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // weight pipeline: floor(a_k * 2^24 / sum a), restoring, per lane
  // ---------------------------------------------------------------------------
  logic [R2W-1:0]        d2_rem_r [D2N][3];
  logic [Q2W-1:0]        d2_q_r   [D2N][3];
  logic [ALPHA_BITS-1:0] d2_d_r   [D2N];

  for (genvar t = 0; t < D2N; t++) begin : g_d2
    logic [R2W-1:0]        rem_i [3];
    logic [Q2W-1:0]        q_i   [3];
    logic                  b0_i  [3];
    logic [ALPHA_BITS-1:0] d_i;
    logic [R2W-1:0]        rem_nxt [3];
    logic [Q2W-1:0]        q_nxt   [3];
    if (t == 0) begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = R2W'(als_r[l] >> 1);
          q_i[l]   = '0;
          b0_i[l]  = als_r[l][0];
        end
        d_i = a2_r;
      end
    end else begin : g_src
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = d2_rem_r[t-1][l];
          q_i[l]   = d2_q_r[t-1][l];
          b0_i[l]  = 1'b0;
        end
        d_i = d2_d_r[t-1];
      end
    end
    always_comb begin
      logic [R2W-1:0] r;
      logic [Q2W-1:0] q;
      logic           ge;
      for (int l = 0; l < 3; l++) begin
        r  = rem_i[l];
        q  = q_i[l];
        ge = 1'b0;
        for (int j = 0; j < DIV2_STEPS; j++) begin
          if (t * DIV2_STEPS + j < Q2W) begin
            r  = {r[R2W-2:0], (t * DIV2_STEPS + j == 0) ? b0_i[l] : 1'b0};
            ge = (r >= {1'b0, d_i});
            if (ge) r = r - {1'b0, d_i};
            q  = {q[Q2W-2:0], ge};
          end
        end
        rem_nxt[l] = r;
        q_nxt[l]   = q;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          d2_rem_r[t][l] <= rem_nxt[l];
          d2_q_r[t][l]   <= q_nxt[l];
        end
        d2_d_r[t] <= d_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // blend: split products, sum, floor by 2^25, clamp
  // ---------------------------------------------------------------------------
  logic [Q2W+PLW-1:0]          prl_r [3];
  logic signed [Q2W+PHW:0]     prh_r [3];
  logic signed [Y2W-1:0]       y2_r;
  logic [UW-1:0]               u_r;

  logic signed [Y2W-1:0]       y2_nxt;
  logic [UW-1:0]               u_nxt;
  logic                        cl_sat_nxt;

  always_comb begin
    logic signed [NW-1:0] num;
    num = NW'(3) << WGT_BITS;
    for (int k = 0; k < 3; k++) begin
      num = num + (NW'(prh_r[k]) <<< PLW) + NW'(prl_r[k]);
    end
    y2_nxt = num[NW-1:WGT_BITS+1];
  end

  always_comb begin
    logic signed [Y2W-1:0] yc;
    logic signed [Y2W-1:0] df;
    cl_sat_nxt = (y2_r > CL_HI) || (y2_r < CL_LO);
    if (y2_r > CL_HI)      yc = CL_HI;
    else if (y2_r < CL_LO) yc = CL_LO;
    else                   yc = y2_r;
    df    = yc - CL_LO;
    u_nxt = df[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prl_r[k] <= d2_q_r[D2N-1][k] * cr_r[ST_MP-1].p[k][PLW-1:0];
        prh_r[k] <= $signed({1'b0, d2_q_r[D2N-1][k]}) * $signed(cr_r[ST_MP-1].p[k][PW-1:PLW]);
      end
      y2_r <= y2_nxt;
      u_r  <= u_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // divide by three: split products with the reciprocal, then sum and shift
  // ---------------------------------------------------------------------------
  logic [2*ML-1:0]    d3_ll_r;
  logic [ML+RHW-1:0]  d3_lh_r;
  logic [UHW+ML-1:0]  d3_hl_r;
  logic [UHW+RHW-1:0] d3_hh_r;
  logic [UW-1:0]      d3_q_r;
  logic [PRW-1:0]     d3_prod;

  assign d3_prod = PRW'(d3_ll_r) + (PRW'(d3_lh_r) << ML) + (PRW'(d3_hl_r) << ML) +
                   (PRW'(d3_hh_r) << (2 * ML));

  always_ff @(posedge clk) begin
    if (en) begin
      d3_ll_r <= u_r[ML-1:0] * RC_M[ML-1:0];
      d3_lh_r <= u_r[ML-1:0] * RC_M[RMW-1:ML];
      d3_hl_r <= u_r[UW-1:ML] * RC_M[ML-1:0];
      d3_hh_r <= u_r[UW-1:ML] * RC_M[RMW-1:ML];
      d3_q_r  <= d3_prod[RCK +: UW];
    end
  end

  // ---------------------------------------------------------------------------
  // output stage and side-data shift line
  // ---------------------------------------------------------------------------
  carry_t cl_cr_nxt;

  // clamp flag joins the side data as it enters the clamp stage
  always_comb begin
    cl_cr_nxt     = cr_r[ST_CL-1];
    cl_cr_nxt.sat = cl_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= cr0_nxt;
      for (int s = 1; s < NST; s++) begin
        if (s == ST_CL) cr_r[s] <= cl_cr_nxt;
        else            cr_r[s] <= cr_r[s-1];
      end
      // quotient offset back by the minimum: flip its top bit
      if (cr_r[ST_OUT-1].zero) begin
        o_val_r <= '0;
        o_sat_r <= 1'b0;
      end else begin
        o_val_r <= {~d3_q_r[DW-1], d3_q_r[DW-2:0]};
        o_sat_r <= cr_r[ST_OUT-1].sat;
      end
    end
  end

`ifndef ASSERT_OFF
  // a stalled input always means a result is waiting at the output
  a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending output");

  // a clipped result sits on one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[DW]) |->
      (out_tdata[DW-1:0] == {1'b0, {(DW-1){1'b1}}} ||
       out_tdata[DW-1:0] == {1'b1, {(DW-1){1'b0}}}))
    else $error("saturated flag without limit value");

  // normalized weights never exceed one
  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_MP-1] |->
      (d2_q_r[D2N-1][0] <= (Q2W'(1) << WGT_BITS) &&
       d2_q_r[D2N-1][1] <= (Q2W'(1) << WGT_BITS) &&
       d2_q_r[D2N-1][2] <= (Q2W'(1) << WGT_BITS)))
    else $error("weight quotient out of range");
`endif

endmodule

`default_nettype wire
